// ===== rtl/avt_pkg.sv =====
`timescale 1ns / 1ps

package avt_pkg;

  // Sizing
  localparam int TASK_COUNT   = 16;
  localparam int WINDOW_DEPTH = 8;

  // Field widths
  localparam int TASK_NUM_W = 4;
  localparam int BYTES_W    = 24;
  localparam int TIME_W     = 32;
  localparam int VEL_W      = 32;
  localparam int TOTAL_W    = 27;
  localparam int ACC_W      = 32;
  localparam int CFG_W      = 32;

  // Stream payloads, packed from bit 0 up, padded to whole bytes
  localparam int S_DATA_W = 64;
  localparam int M_DATA_W = 64;

  // Derived storage geometry
  localparam int TASK_AW     = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int SLOT_W      = $clog2(WINDOW_DEPTH);
  localparam int WIN_AW      = TASK_AW + SLOT_W;
  localparam int WIN_ENTRIES = 1 << WIN_AW;
  localparam int RATE_DEPTH  = 1 << TASK_AW;
  localparam int ENTRY_W     = TIME_W + BYTES_W;

  // Rate scaling (ms -> s)
  localparam int             RATE_SCALE_W = 10;
  localparam logic [RATE_SCALE_W-1:0] RATE_SCALE = 10'd1000;

  // Divider
  localparam int DIV_W  = 32;
  localparam int DIV_CW = $clog2(DIV_W);

  // Configuration port
  localparam int                PADDR_W       = 3;
  localparam int                REG_IDX_W     = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_W-1:0]     THRESH_RESET  = 32'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_WALK,
    ST_LAST,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } avt_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } avt_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } avt_div_rsp_t;

endpackage

// ===== rtl/avt_ram.sv =====
`timescale 1ns / 1ps

module avt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/avt_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module avt_div (
  input  logic                  clk,
  input  logic                  rst,
  input  avt_pkg::avt_div_req_t req,
  output avt_pkg::avt_div_rsp_t rsp
);
  import avt_pkg::*;

  logic              busy;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/alloc_velocity_tracker_core.sv =====
`timescale 1ns / 1ps
// Per input item: write, window walk, multiply, divide, finish; the divide is skipped
//   when the window span is zero, and an out-of-range task goes straight to finish.
// One item is in flight at a time; the walk over the window RAM and the 32-step
//   bit-serial divider set the pace. Input is taken again once the result
//   sits in the output register, even if it is not yet taken.
// Reset: synchronous; valid bits clear both RAMs at once, no clearing pass.

module alloc_velocity_tracker_core (
  input  logic                          clk,
  input  logic                          rst,
  // input item
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [3:0] task_number, [27:4] alloc_bytes, [59:28] now_ms, [63:60] zero
  input  logic [avt_pkg::S_DATA_W-1:0]  s_tdata,
  // result item
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] velocity, [58:32] window_total, [59] abusive, [63:60] zero
  output logic [avt_pkg::M_DATA_W-1:0]  m_tdata,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [avt_pkg::PADDR_W-1:0]   paddr,
  input  logic [avt_pkg::CFG_W-1:0]     pwdata,
  output logic [avt_pkg::CFG_W-1:0]     prdata,
  output logic                          pready
);
  import avt_pkg::*;

  localparam int IN_BYTES_LO = TASK_NUM_W;
  localparam int IN_TIME_LO  = TASK_NUM_W + BYTES_W;
  localparam int OUT_USED    = VEL_W + TOTAL_W + 1;
  localparam int OUT_PAD     = M_DATA_W - OUT_USED;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Input unpack
  // ---------------------------------------------------------------------------
  logic [TASK_NUM_W-1:0] in_task;
  logic [BYTES_W-1:0]    in_bytes;
  logic [TIME_W-1:0]     in_now;
  logic                  in_range;
  logic                  in_accept;

  assign in_task   = s_tdata[TASK_NUM_W-1:0];
  assign in_bytes  = s_tdata[IN_TIME_LO-1:IN_BYTES_LO];
  assign in_now    = s_tdata[IN_TIME_LO+TIME_W-1:IN_TIME_LO];
  assign in_range  = (int'(in_task) < TASK_COUNT);
  assign in_accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] threshold;
  logic             cfg_wr;
  logic             cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_THRESHOLD);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = cfg_hit ? threshold : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_wr && cfg_hit) begin
      threshold <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // State and working registers
  // ---------------------------------------------------------------------------
  avt_state_t            state;
  avt_state_t            state_next;

  logic [TASK_NUM_W-1:0] task_q;
  logic [BYTES_W-1:0]    bytes_q;
  logic [TIME_W-1:0]     now_q;
  logic [TASK_AW-1:0]    task_idx;

  logic [SLOT_W-1:0]     ptr [TASK_COUNT];
  logic [WIN_ENTRIES-1:0] win_vld;
  logic [RATE_DEPTH-1:0] rate_vld;

  logic [SLOT_W-1:0]     idx;
  logic                  rd_pend;
  logic                  rd_vld;

  logic [ACC_W-1:0]      acc;
  logic [TIME_W-1:0]     oldest;
  logic [TIME_W-1:0]     newest;
  logic [VEL_W-1:0]      vel;

  logic                  out_load;
  logic [VEL_W-1:0]      out_vel;
  logic [TOTAL_W-1:0]    out_total;
  logic                  out_abusive;

  assign task_idx = task_q[TASK_AW-1:0];

  // Window RAM: {time, size} per slot, addressed {task, slot}
  logic                  win_we;
  logic [WIN_AW-1:0]     win_waddr;
  logic [ENTRY_W-1:0]    win_wdata;
  logic [WIN_AW-1:0]     win_raddr;
  logic [ENTRY_W-1:0]    win_rdata;

  assign win_we    = (state == ST_WRITE);
  assign win_waddr = {task_idx, ptr[task_idx]};
  assign win_wdata = {now_q, bytes_q};
  assign win_raddr = {task_idx, idx};

  avt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WIN_ENTRIES)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  // Per-task rate RAM; read address follows the current task
  logic                  rate_we;
  logic [VEL_W-1:0]      rate_rdata;
  logic [VEL_W-1:0]      rate_old;

  avt_div_req_t          div_req;
  avt_div_rsp_t          div_rsp;

  assign rate_we  = (state == ST_DIV) && div_rsp.done;
  assign rate_old = rate_vld[task_idx] ? rate_rdata : '0;

  avt_ram #(
    .WIDTH (VEL_W),
    .DEPTH (RATE_DEPTH)
  ) u_rate_ram (
    .clk   (clk),
    .we    (rate_we),
    .waddr (task_idx),
    .wdata (div_rsp.quotient),
    .raddr (task_idx),
    .rdata (rate_rdata)
  );

  // ---------------------------------------------------------------------------
  // Window walk datapath
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0]              ent_time;
  logic [BYTES_W-1:0]             ent_size;
  logic [TIME_W-1:0]              span;
  logic [ACC_W+RATE_SCALE_W-1:0]  prod_full;

  // Never-written slots read as zero
  assign ent_time  = rd_vld ? win_rdata[ENTRY_W-1:BYTES_W] : '0;
  assign ent_size  = rd_vld ? win_rdata[BYTES_W-1:0] : '0;
  assign span      = newest - oldest;
  assign prod_full = acc * RATE_SCALE;

  avt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = prod_full[DIV_W-1:0];
    div_req.divisor  = span;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = in_range ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (idx == SLOT_LAST) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (span != '0) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        ptr[i] <= '0;
      end
      win_vld  <= '0;
      rate_vld <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= (state == ST_WALK);
      if (state == ST_WRITE) begin
        win_vld[win_waddr] <= 1'b1;
        ptr[task_idx]      <= (ptr[task_idx] == SLOT_LAST) ? '0 : ptr[task_idx] + 1'b1;
      end
      if (rate_we) begin
        rate_vld[task_idx] <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      task_q  <= in_task;
      bytes_q <= in_bytes;
      now_q   <= in_now;
      acc     <= '0;
      oldest  <= in_now;
      newest  <= '0;
      vel     <= '0;
    end
    if (state == ST_WALK) begin
      idx    <= (idx == SLOT_LAST) ? '0 : idx + 1'b1;
      rd_vld <= win_vld[win_raddr];
    end else if (state == ST_WRITE) begin
      idx <= '0;
    end
    if (rd_pend) begin
      acc <= acc + ACC_W'(ent_size);
      if ((ent_time != '0) && (ent_time < oldest)) begin
        oldest <= ent_time;
      end
      if (ent_time > newest) begin
        newest <= ent_time;
      end
    end
    if ((state == ST_MUL) && (span == '0)) begin
      vel <= rate_old;
    end
    if (rate_we) begin
      vel <= div_rsp.quotient;
    end
    if (out_load) begin
      out_vel     <= vel;
      out_total   <= acc[TOTAL_W-1:0];
      out_abusive <= (vel > threshold);
    end
  end

  assign m_tdata = {{OUT_PAD{1'b0}}, out_abusive, out_total, out_vel};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_rd_after_walk: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> ($past(state) == ST_WALK))
    else $error("window read data consumed without a walk issue");

  a_slot_marked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> win_vld[$past(win_waddr)])
    else $error("written window slot not marked valid");

  a_ptr_moves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> (ptr[$past(task_idx)] != $past(ptr[task_idx])))
    else $error("ring pointer did not advance after a write");

endmodule
